// ===== rtl/core/smkh_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the
// smallest-k max-heap unit. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package smkh_pkg;

  // Heap store depth and the widths derived from it.
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Fixed field widths.
  localparam int DATA_W   = 32;
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;
  localparam int SIZE_W   = 7;

  // Width for child positions, sizes and index compares.
  localparam int POS_W = (IDX_W + 2 > SIZE_W + 1) ? IDX_W + 2 : SIZE_W + 1;

  localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 7'd64;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_HEAP_SIZE = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_OFFER = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_LATCH,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic build_init;
    logic offer_start;
    logic read_issue;
    logic read_capture;
    logic fetch;
    logic latch;
    logic child_rd;
    logic move;
    logic final_wr;
    logic build_dec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    idx_ok;
    logic    size_zero;
    logic    offer_take;
    logic    has_child;
    logic    child_bigger;
    logic    more_build;
    logic    out_free;
  } status_t;

endpackage

// ===== rtl/core/smkh_if.sv =====
// Valid/ready channel interfaces for items in and results out.
// Depends on smkh_pkg for the field widths.
`timescale 1ns / 1ps

interface smkh_req_if;
  logic                          valid;
  logic                          ready;
  logic [smkh_pkg::ACTION_W-1:0] action;
  logic [smkh_pkg::INDEX_W-1:0]  index;
  logic [smkh_pkg::DATA_W-1:0]   value;

  modport source (output valid, action, index, value, input ready);
  modport sink (input valid, action, index, value, output ready);
endinterface

interface smkh_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [smkh_pkg::DATA_W-1:0] root_value;
  logic [smkh_pkg::DATA_W-1:0] read_value;
  logic                        replaced;

  modport source (output valid, root_value, read_value, replaced, input ready);
  modport sink (input valid, root_value, read_value, replaced, output ready);
endinterface

// ===== rtl/core/smallest_k_max_heap_unit.sv =====
// Top level of the smallest-k max-heap unit: configuration register port,
// controller and datapath. Depends on smkh_pkg, smkh_if, smkh_ctrl, smkh_datapath.
//
// The unit keeps the K smallest values offered in a binary max-heap of
// heap_size entries (saturated at the store depth) and works on one item at
// a time. Each result is loaded into the result register after the work
// ends; the next item is accepted while that result still waits. An offer
// that replaces the root sinks the new value level by level until it comes
// to rest at a leaf or above one. Each level reads both children through
// the two read ports of the heap memory, then compares and writes through
// its single write port. A build sifts every node from half the size in use
// down to node 0. The store needs no clearing after reset; its entries must be
// loaded before they are read, built or offered against.
`timescale 1ns / 1ps

module smallest_k_max_heap_unit (
  input  logic                         clk,
  input  logic                         rst,
  smkh_req_if.sink                     req,
  smkh_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smkh_pkg::PADDR_W-1:0] paddr,
  input  logic [smkh_pkg::PDATA_W-1:0] pwdata,
  output logic [smkh_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [smkh_pkg::SIZE_W-1:0] heap_size;
  logic                        reg_sel;
  smkh_pkg::cmd_t              cmd;
  smkh_pkg::status_t           status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[smkh_pkg::PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= smkh_pkg::HEAP_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == smkh_pkg::REG_HEAP_SIZE) begin
      heap_size <= pwdata[smkh_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == smkh_pkg::REG_HEAP_SIZE) begin
      prdata = smkh_pkg::PDATA_W'(heap_size);
    end
  end

  smkh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  smkh_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .heap_size      (heap_size),
    .req_action     (req.action),
    .req_index      (req.index),
    .req_value      (req.value),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_root_value (rsp.root_value),
    .rsp_read_value (rsp.read_value),
    .rsp_replaced   (rsp.replaced)
  );

endmodule

// ===== rtl/core/smkh_ctrl.sv =====
// Controller state machine of the smallest-k max-heap unit: sequences load,
// build, offer and read over the datapath. Depends on smkh_pkg.
`timescale 1ns / 1ps

module smkh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  smkh_pkg::status_t status,
  output smkh_pkg::cmd_t    cmd
);

  smkh_pkg::state_t state;
  smkh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smkh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      smkh_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = smkh_pkg::ST_EXEC;
        end
      end
      smkh_pkg::ST_EXEC: begin
        unique case (status.action)
          smkh_pkg::ACT_LOAD: begin
            cmd.load_wr = status.idx_ok;
            state_next  = smkh_pkg::ST_DONE;
          end
          smkh_pkg::ACT_BUILD: begin
            if (status.size_zero) begin
              state_next = smkh_pkg::ST_DONE;
            end else begin
              cmd.build_init = 1'b1;
              state_next     = smkh_pkg::ST_FETCH;
            end
          end
          smkh_pkg::ACT_OFFER: begin
            if (status.offer_take) begin
              cmd.offer_start = 1'b1;
              state_next      = smkh_pkg::ST_SIFT_RD;
            end else begin
              state_next = smkh_pkg::ST_DONE;
            end
          end
          smkh_pkg::ACT_READ: begin
            if (status.idx_ok) begin
              cmd.read_issue = 1'b1;
              state_next     = smkh_pkg::ST_READ_WAIT;
            end else begin
              state_next = smkh_pkg::ST_DONE;
            end
          end
          default: state_next = smkh_pkg::ST_DONE;
        endcase
      end
      smkh_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = smkh_pkg::ST_LATCH;
      end
      smkh_pkg::ST_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = smkh_pkg::ST_SIFT_RD;
      end
      smkh_pkg::ST_SIFT_RD, smkh_pkg::ST_SIFT_CMP: begin
        if (state == smkh_pkg::ST_SIFT_RD && status.has_child) begin
          cmd.child_rd = 1'b1;
          state_next   = smkh_pkg::ST_SIFT_CMP;
        end else if (state == smkh_pkg::ST_SIFT_CMP && status.child_bigger) begin
          cmd.move   = 1'b1;
          state_next = smkh_pkg::ST_SIFT_RD;
        end else begin
          // The sifted value comes to rest here; a build goes on to the
          // next lower node until node zero is done.
          cmd.final_wr = 1'b1;
          if (status.more_build) begin
            cmd.build_dec = 1'b1;
            state_next    = smkh_pkg::ST_FETCH;
          end else begin
            state_next = smkh_pkg::ST_DONE;
          end
        end
      end
      smkh_pkg::ST_READ_WAIT: begin
        cmd.read_capture = 1'b1;
        state_next       = smkh_pkg::ST_DONE;
      end
      smkh_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = smkh_pkg::ST_IDLE;
        end
      end
      default: state_next = smkh_pkg::ST_IDLE;
    endcase
  end

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == smkh_pkg::ST_SIFT_CMP |-> $past(state) == smkh_pkg::ST_SIFT_RD)
    else $error("child compare without a preceding child read");

  a_latch_after_fetch: assert property (@(posedge clk) disable iff (rst)
    state == smkh_pkg::ST_LATCH |-> $past(state) == smkh_pkg::ST_FETCH)
    else $error("node value latched without a fetch");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == smkh_pkg::ST_EXEC)
    else $error("accepted item did not start execution");

endmodule

// ===== rtl/core/smkh_datapath.sv =====
// Datapath of the smallest-k max-heap unit: heap store memory, sift-down
// registers and compare, root mirror and result register. Depends on smkh_pkg.
`timescale 1ns / 1ps

module smkh_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [smkh_pkg::SIZE_W-1:0]   heap_size,
  input  logic [smkh_pkg::ACTION_W-1:0] req_action,
  input  logic [smkh_pkg::INDEX_W-1:0]  req_index,
  input  logic [smkh_pkg::DATA_W-1:0]   req_value,
  input  smkh_pkg::cmd_t                cmd,
  output smkh_pkg::status_t             status,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [smkh_pkg::DATA_W-1:0]   rsp_root_value,
  output logic [smkh_pkg::DATA_W-1:0]   rsp_read_value,
  output logic                          rsp_replaced
);

  localparam int IW = smkh_pkg::IDX_W;
  localparam int PW = smkh_pkg::POS_W;
  localparam int DW = smkh_pkg::DATA_W;

  logic [DW-1:0] heap_mem [smkh_pkg::MAX_ENTRIES];
  logic [DW-1:0] rdata0;
  logic [DW-1:0] rdata1;
  logic [IW-1:0] raddr0;
  logic [IW-1:0] raddr1;
  logic          we;
  logic [IW-1:0] waddr;
  logic [DW-1:0] wdata;

  smkh_pkg::action_t            act;
  logic [smkh_pkg::INDEX_W-1:0] idx;
  logic [DW-1:0]                val;
  logic [IW-1:0]                node;
  logic [IW-1:0]                build_i;
  logic [DW-1:0]                sift_val;
  logic [DW-1:0]                root;
  logic [DW-1:0]                rd_val;
  logic                         rep;

  logic [PW-1:0] n;
  logic [PW-1:0] left;
  logic [PW-1:0] right;
  logic          right_ok;
  logic          pick_right;
  logic [DW-1:0] cand;
  logic [IW-1:0] cand_pos;

  // Size in use saturates at the store depth.
  assign n = (PW'(heap_size) > PW'(smkh_pkg::MAX_ENTRIES)) ?
             PW'(smkh_pkg::MAX_ENTRIES) : PW'(heap_size);

  assign left       = PW'({node, 1'b1});
  assign right      = left + PW'(1);
  assign right_ok   = right < n;
  assign pick_right = right_ok && (rdata1 > rdata0);
  assign cand       = pick_right ? rdata1 : rdata0;
  assign cand_pos   = pick_right ? right[IW-1:0] : left[IW-1:0];

  always_comb begin
    status.action       = act;
    status.idx_ok       = PW'(idx) < n;
    status.size_zero    = n == '0;
    status.offer_take   = (n != '0) && (val < root);
    status.has_child    = left < n;
    status.child_bigger = cand > sift_val;
    status.more_build   = (act == smkh_pkg::ACT_BUILD) && (build_i != '0);
    status.out_free     = !rsp_valid || rsp_ready;
  end

  always_comb begin
    raddr0 = left[IW-1:0];
    if (cmd.fetch) begin
      raddr0 = build_i;
    end else if (cmd.read_issue) begin
      raddr0 = IW'(idx);
    end
    raddr1 = right[IW-1:0];

    we    = cmd.load_wr || cmd.move || cmd.final_wr;
    waddr = node;
    wdata = sift_val;
    if (cmd.load_wr) begin
      waddr = IW'(idx);
      wdata = val;
    end else if (cmd.move) begin
      wdata = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rdata0 <= heap_mem[raddr0];
    rdata1 <= heap_mem[raddr1];
  end

  // Entry zero is mirrored in a register so the root is always at hand.
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (we && waddr == '0) begin
      root <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= smkh_pkg::action_t'(req_action);
      idx    <= req_index;
      val    <= req_value;
      rd_val <= '0;
      rep    <= 1'b0;
    end
    if (cmd.build_init) begin
      build_i <= IW'(n >> 1);
    end else if (cmd.build_dec) begin
      build_i <= build_i - IW'(1);
    end
    if (cmd.offer_start) begin
      sift_val <= val;
      node     <= '0;
      rep      <= 1'b1;
    end
    if (cmd.fetch) begin
      node <= build_i;
    end
    if (cmd.latch) begin
      sift_val <= rdata0;
    end
    if (cmd.move) begin
      node <= cand_pos;
    end
    if (cmd.read_capture) begin
      rd_val <= rdata0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_root_value <= (n == '0) ? '0 : root;
      rsp_read_value <= rd_val;
      rsp_replaced   <= rep;
    end
  end

  a_move_goes_down: assert property (@(posedge clk) disable iff (rst)
    cmd.move |=> node > $past(node))
    else $error("sift step did not move to a child");

  a_root_mirror: assert property (@(posedge clk) disable iff (rst)
    (we && waddr == '0) |=> root == $past(wdata))
    else $error("root register lost a write to entry zero");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result overwritten before it was taken");

  a_child_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.child_rd |-> PW'(node) < n)
    else $error("child read issued for a node outside the heap");

endmodule

// ===== verif/tb_smallest_k_max_heap_unit.sv =====
// Self-checking testbench for smallest_k_max_heap_unit: drives items and APB writes,
// predicts every result with its own heap copy and compares field by field.
// Depends on smkh_pkg, smkh_if and the unit itself.
`timescale 1ns / 1ps

module tb_smallest_k_max_heap_unit;
  import smkh_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [PADDR_W-1:0] HEAP_SIZE_ADDR = {{(PADDR_W-1){1'b0}}, REG_HEAP_SIZE} << 2;

  typedef struct packed {
    logic [DATA_W-1:0] root_value;
    logic [DATA_W-1:0] read_value;
    logic              replaced;
  } heap_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  smkh_req_if req_ch ();
  smkh_rsp_if rsp_ch ();

  smallest_k_max_heap_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Own copy of the heap store and of the size register.
  logic [DATA_W-1:0] kept_values [MAX_ENTRIES];
  int unsigned       size_cfg;
  heap_result_t      pending_results [$];

  int          failures;
  int          items_sent;
  int          roots_displaced;
  int          sizes_tried;
  bit          idling_on;
  int unsigned hold_off_len;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int active_size();
    return (size_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(size_cfg);
  endfunction

  // Iterative sift-down of one node within the first n entries.
  function automatic void sink_node(int node, int n);
    int left;
    int big;
    logic [DATA_W-1:0] t;
    while (node < n) begin
      left = 2 * node + 1;
      big = node;
      if (left < n && kept_values[left] > kept_values[big]) big = left;
      if (left + 1 < n && kept_values[left + 1] > kept_values[big]) big = left + 1;
      if (big == node) break;
      t = kept_values[node];
      kept_values[node] = kept_values[big];
      kept_values[big] = t;
      node = big;
    end
  endfunction

  function automatic heap_result_t predict_heap_step(action_t act, logic [INDEX_W-1:0] idx,
                                                    logic [DATA_W-1:0] val);
    heap_result_t r;
    int n;
    n = active_size();
    r = '0;
    case (act)
      ACT_LOAD: begin
        if (idx < n) kept_values[idx] = val;
      end
      ACT_BUILD: begin
        if (n > 0)
          for (int i = n / 2; i >= 0; i--) sink_node(i, n);
      end
      ACT_OFFER: begin
        if (n > 0 && val < kept_values[0]) begin
          kept_values[0] = val;
          sink_node(0, n);
          r.replaced = 1'b1;
        end
      end
      default: begin
        if (idx < n) r.read_value = kept_values[idx];
      end
    endcase
    r.root_value = (n > 0) ? kept_values[0] : '0;
    return r;
  endfunction

  // Values cluster around the extremes, a small range and the current root so that
  // equal and near-equal compares happen often.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return DATA_W'($urandom_range(0, 31));
      4: return kept_values[0] - 1;
      5: return kept_values[0];
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input action_t act, input logic [INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    heap_result_t r;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.index  <= idx;
    req_ch.value  <= val;
    do @(posedge clk); while (!req_ch.ready);
    r = predict_heap_step(act, idx, val);
    if (act == ACT_OFFER && r.replaced) roots_displaced++;
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_random_item();
    int n;
    int unsigned pick;
    logic [INDEX_W-1:0] idx;
    n = active_size();
    pick = $urandom_range(0, 19);
    if (n > 0 && $urandom_range(0, 3) != 0)
      idx = INDEX_W'($urandom_range(0, n - 1));
    else
      idx = INDEX_W'($urandom_range(0, 63));
    if (pick < 9)
      send_item(ACT_OFFER, INDEX_W'($urandom_range(0, 63)), pick_value());
    else if (pick < 15)
      send_item(ACT_READ, idx, $urandom());
    else if (pick < 19)
      send_item(ACT_LOAD, idx, pick_value());
    else
      send_item(ACT_BUILD, INDEX_W'($urandom_range(0, 63)), $urandom());
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_heap_size_reg();
    logic [PDATA_W-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HEAP_SIZE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(size_cfg)) begin
      $display("%0t: heap_size readback mismatch, expected %0d, actual %0d",
               $time, size_cfg, readback);
      failures++;
    end
  endtask

  // Writes only once the unit has delivered every outstanding result.
  task automatic set_heap_size(input logic [SIZE_W-1:0] size);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HEAP_SIZE_ADDR;
    pwdata  <= {{(PDATA_W-SIZE_W){1'b0}}, size};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_cfg = size;
    check_heap_size_reg();
  endtask

  // Every entry is written once at full size so no later step touches an unwritten one.
  task automatic test_fill_store();
    logic [DATA_W-1:0] val;
    check_heap_size_reg();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      val = (i == 17) ? '1 : (i == 40) ? '0 : $urandom();
      send_item(ACT_LOAD, INDEX_W'(i), val);
    end
    send_item(ACT_BUILD, '0, '0);
  endtask

  task automatic test_directed_cases();
    send_item(ACT_READ, 6'd0, '1);
    send_item(ACT_READ, 6'd63, '0);
    // Root is the all-ones word here, so this offer ties and is refused.
    send_item(ACT_OFFER, 6'd0, '1);
    send_item(ACT_OFFER, 6'd63, '0);
    wait_drained();
    send_item(ACT_OFFER, 6'd0, kept_values[0]);
    send_item(ACT_OFFER, 6'd0, kept_values[0] - 1);
    send_item(ACT_BUILD, 6'd0, '0);
    send_item(ACT_LOAD, 6'd63, '1);
    send_item(ACT_BUILD, 6'd63, '1);
    send_item(ACT_READ, 6'd63, '0);

    // A load or read past the size in use is dropped or reads as zero.
    set_heap_size(7'd5);
    send_item(ACT_LOAD, 6'd10, 32'h1234_5678);
    send_item(ACT_READ, 6'd10, '0);
    send_item(ACT_READ, 6'd4, '0);
    send_item(ACT_LOAD, 6'd0, '0);
    send_item(ACT_BUILD, 6'd0, '0);
    send_item(ACT_OFFER, 6'd0, '0);

    // An empty heap ignores everything and reports zeros.
    set_heap_size(7'd0);
    send_item(ACT_LOAD, 6'd0, 32'd123);
    send_item(ACT_BUILD, 6'd0, '0);
    send_item(ACT_OFFER, 6'd0, '0);
    send_item(ACT_READ, 6'd0, '0);

    // Sizes above the store depth saturate.
    set_heap_size(7'd127);
    send_item(ACT_READ, 6'd63, '0);
    send_item(ACT_LOAD, 6'd63, 32'h0000_0001);
    send_item(ACT_BUILD, 6'd0, '0);
    send_item(ACT_OFFER, 6'd0, $urandom());
    set_heap_size(7'd65);
    send_item(ACT_READ, 6'd0, '0);
  endtask

  // Each size gets a full load in shuffled order, a build unless it is empty, then mixed traffic.
  task automatic run_size_phase(input logic [SIZE_W-1:0] size);
    int n;
    int j;
    int tmp;
    int slot [MAX_ENTRIES];
    set_heap_size(size);
    idling_on = ($urandom_range(0, 3) != 0);
    n = active_size();
    for (int i = 0; i < n; i++) slot[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = slot[i];
      slot[i] = slot[j];
      slot[j] = tmp;
    end
    for (int i = 0; i < n; i++) send_item(ACT_LOAD, INDEX_W'(slot[i]), pick_value());
    if (n > 0) send_item(ACT_BUILD, INDEX_W'($urandom_range(0, 63)), $urandom());
    repeat (35) send_random_item();
    sizes_tried++;
  endtask

  task automatic test_random_sizes();
    logic [SIZE_W-1:0] sizes [16];
    sizes = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd31, 7'd32, 7'd33, 7'd63, 7'd64,
              7'd65, 7'd100, 7'd127, 7'd0, 7'd1};
    sizes[15] = SIZE_W'($urandom_range(1, 127));
    foreach (sizes[i]) run_size_phase(sizes[i]);
  endtask

  // The receiver stops for a long stretch while items keep coming, so the unit backs up.
  task automatic test_output_hold();
    set_heap_size(7'd64);
    idling_on = 1'b1;
    hold_off_len = 200;
    repeat (30) send_random_item();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      repeat (8) send_random_item();
      wait_drained();
    end
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    set_heap_size(7'd48);
    send_item(ACT_BUILD, '0, '0);
    repeat (80) send_random_item();
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stretch;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        stretch = hold_off_len;
        hold_off_len = 0;
        rsp_ch.ready <= 1'b0;
        repeat (stretch - 1) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stretch = $urandom_range(1, 4);
        rsp_ch.ready <= 1'b0;
        repeat (stretch - 1) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual root %h read %h replaced %b",
                 $time, rsp_ch.root_value, rsp_ch.read_value, rsp_ch.replaced);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.root_value !== want.root_value) begin
          $display("%0t: root_value mismatch, expected %h, actual %h",
                   $time, want.root_value, rsp_ch.root_value);
          failures++;
        end
        if (rsp_ch.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h",
                   $time, want.read_value, rsp_ch.read_value);
          failures++;
        end
        if (rsp_ch.replaced !== want.replaced) begin
          $display("%0t: replaced mismatch, expected %b, actual %b",
                   $time, want.replaced, rsp_ch.replaced);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_LOAD;
    req_ch.index  <= '0;
    req_ch.value  <= '0;
    quiet_cycles  = 0;
    hold_off_len  = 0;
    idling_on     = 1'b1;
    failures      = 0;
    items_sent    = 0;
    roots_displaced = 0;
    sizes_tried   = 0;
    size_cfg      = HEAP_SIZE_RESET;
    foreach (kept_values[i]) kept_values[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_fill_store();
    test_directed_cases();
    test_random_sizes();
    test_output_hold();
    test_drain_pause();
    test_steady_stream();

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d items over %0d random heap sizes plus directed edge sizes;",
             items_sent, sizes_tried);
    $display("%0d offers displaced the root, with a long output stall and drain pauses.",
             roots_displaced);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
